// ----- rtl/utss_pkg.sv -----
package utss_pkg;

  // Table geometry
  localparam int DEPTH   = 64;
  localparam int ENTRY_W = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMD_W   = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 2'd3;

  // Search token that walks the cell chain
  typedef struct packed {
    logic               vld;
    logic               hit;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] data;
  } tok_t;

  // Broadcast control seen by every cell
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [CNT_W-1:0] count;
  } ctl_t;

  // Broadcast entry write
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] data;
  } wr_t;

endpackage

// ----- rtl/utss_in_if.sv -----
interface utss_in_if;
  import utss_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [IDX_W-1:0]    index;
  logic [ENTRY_W-1:0]  entry_value;

  modport source (output valid, output command, output index, output entry_value,
                  input ready);
  modport sink   (input valid, input command, input index, input entry_value,
                  output ready);
endinterface

// ----- rtl/utss_out_if.sv -----
interface utss_out_if;
  import utss_pkg::*;

  logic              valid;
  logic              ready;
  logic              ok;
  logic [IDX_W-1:0]  found_index;
  logic [CNT_W-1:0]  live_count;

  modport source (output valid, output ok, output found_index, output live_count,
                  input ready);
  modport sink   (input valid, input ok, input found_index, input live_count,
                  output ready);
endinterface

// ----- rtl/utss_cell.sv -----
module utss_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [utss_pkg::IDX_W-1:0] cell_pos,
  input  utss_pkg::ctl_t          ctl,
  input  utss_pkg::wr_t           wr,
  input  utss_pkg::tok_t          tok_in,
  output utss_pkg::tok_t          tok_out
);
  import utss_pkg::*;

  logic [ENTRY_W-1:0] entry_r;
  tok_t               tok_r;
  tok_t               tok_nxt;
  logic               live;
  logic               last;

  // Position is live below the count; last is the top live position
  assign live = CNT_W'(cell_pos) < ctl.count;
  assign last = (CNT_W'(cell_pos) + CNT_W'(1)) == ctl.count;

  // Match the key on lookup, pick up the last entry on remove
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.vld && !tok_in.hit && live) begin
      if (ctl.cmd == CMD_LOOKUP && entry_r == tok_in.data) begin
        tok_nxt.hit = 1'b1;
        tok_nxt.idx = cell_pos;
      end else if (ctl.cmd == CMD_REMOVE && last) begin
        tok_nxt.hit  = 1'b1;
        tok_nxt.data = entry_r;
      end
    end
  end

  // Advance the token one cell per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.hit  <= tok_nxt.hit;
    tok_r.idx  <= tok_nxt.idx;
    tok_r.data <= tok_nxt.data;
  end

  // Store the entry when the write targets this position
  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == cell_pos) begin
      entry_r <= wr.data;
    end
  end

  assign tok_out = tok_r;

endmodule

// ----- rtl/unordered_table_search_swap_remove_unit.sv -----
// Unordered table of DEPTH entries with a live count, one entry per cell in a
// chain. One transaction is worked on at a time. Append, replace and any
// command that fails its range check return a result in the cycle after
// acceptance. Lookup and a valid remove launch a token that steps through the
// cell chain one cell per cycle, through the launch register and each cell's
// token register and then into the result register; lookup reports the first
// live position whose entry equals the key, remove takes the last live entry
// and writes it into the given position. A new transaction is accepted the cycle
// after a result is loaded, provided the output register is free or being drained.
module unordered_table_search_swap_remove_unit (
  input logic        clk,
  input logic        rst_n,
  utss_in_if.sink    in_txn,
  utss_out_if.source out_txn
);
  import utss_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  tok_t             launch_r;
  logic             launch_vld_nxt;
  logic             ovld_r, ovld_nxt;
  logic             ok_r, ok_nxt;
  logic [IDX_W-1:0] fidx_r, fidx_nxt;
  logic [CNT_W-1:0] lcnt_r, lcnt_nxt;

  logic             in_rdy;
  logic             acc;
  logic             pos_ok;
  logic             has_room;
  logic             walk_done;
  ctl_t             ctl;
  wr_t              wr;
  tok_t             tok_feed  [DEPTH];
  tok_t             tok_chain [DEPTH];
  tok_t             tok_end;
  logic [DEPTH:0]   tok_vld_vec;

  assign in_rdy   = (state_r == ST_IDLE) && (!ovld_r || out_txn.ready);
  assign acc      = in_txn.valid && in_rdy;
  assign pos_ok   = CNT_W'(in_txn.index) < count_r;
  assign has_room = count_r < CNT_W'(DEPTH);
  assign tok_end  = tok_chain[DEPTH-1];
  assign walk_done = (state_r == ST_WALK) && tok_end.vld;

  assign ctl.cmd   = cmd_r;
  assign ctl.count = count_r;

  // Cell chain
  assign tok_feed[0]    = launch_r;
  assign tok_vld_vec[0] = launch_r.vld;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign tok_feed[i] = tok_chain[i-1];
    end
    assign tok_vld_vec[i+1] = tok_chain[i].vld;
    utss_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_pos (IDX_W'(i)),
      .ctl      (ctl),
      .wr       (wr),
      .tok_in   (tok_feed[i]),
      .tok_out  (tok_chain[i])
    );
  end

  // Entry write: append and replace at acceptance, remove at end of walk
  always_comb begin
    wr.en   = 1'b0;
    wr.idx  = in_txn.index;
    wr.data = in_txn.entry_value;
    if (acc) begin
      if (in_txn.command == CMD_APPEND && has_room) begin
        wr.en  = 1'b1;
        wr.idx = count_r[IDX_W-1:0];
      end else if (in_txn.command == CMD_REPLACE && pos_ok) begin
        wr.en = 1'b1;
      end
    end else if (walk_done && cmd_r == CMD_REMOVE) begin
      wr.en   = 1'b1;
      wr.idx  = pos_r;
      wr.data = tok_end.data;
    end
  end

  // Sequencer and result register
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cmd_nxt        = cmd_r;
    pos_nxt        = pos_r;
    launch_vld_nxt = 1'b0;
    ovld_nxt       = ovld_r && !out_txn.ready;
    ok_nxt         = ok_r;
    fidx_nxt       = fidx_r;
    lcnt_nxt       = lcnt_r;

    if (acc) begin
      cmd_nxt = in_txn.command;
      pos_nxt = in_txn.index;
      unique case (in_txn.command)
        CMD_APPEND: begin
          ovld_nxt = 1'b1;
          ok_nxt   = has_room;
          fidx_nxt = '0;
          if (has_room) begin
            count_nxt = count_r + CNT_W'(1);
          end
          lcnt_nxt = has_room ? count_r + CNT_W'(1) : count_r;
        end
        CMD_LOOKUP: begin
          launch_vld_nxt = 1'b1;
          state_nxt      = ST_WALK;
        end
        CMD_REMOVE: begin
          if (pos_ok) begin
            launch_vld_nxt = 1'b1;
            state_nxt      = ST_WALK;
          end else begin
            ovld_nxt = 1'b1;
            ok_nxt   = 1'b0;
            fidx_nxt = '0;
            lcnt_nxt = count_r;
          end
        end
        CMD_REPLACE: begin
          ovld_nxt = 1'b1;
          ok_nxt   = pos_ok;
          fidx_nxt = '0;
          lcnt_nxt = count_r;
        end
      endcase
    end else if (walk_done) begin
      state_nxt = ST_IDLE;
      ovld_nxt  = 1'b1;
      if (cmd_r == CMD_LOOKUP) begin
        ok_nxt   = tok_end.hit;
        fidx_nxt = tok_end.hit ? tok_end.idx : '0;
        lcnt_nxt = count_r;
      end else begin
        ok_nxt    = 1'b1;
        fidx_nxt  = '0;
        count_nxt = count_r - CNT_W'(1);
        lcnt_nxt  = count_r - CNT_W'(1);
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      ovld_r       <= 1'b0;
      launch_r.vld <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ovld_r       <= ovld_nxt;
      launch_r.vld <= launch_vld_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    pos_r         <= pos_nxt;
    ok_r          <= ok_nxt;
    fidx_r        <= fidx_nxt;
    lcnt_r        <= lcnt_nxt;
    launch_r.hit  <= 1'b0;
    launch_r.idx  <= '0;
    launch_r.data <= in_txn.entry_value;
  end

  assign in_txn.ready        = in_rdy;
  assign out_txn.valid       = ovld_r;
  assign out_txn.ok          = ok_r;
  assign out_txn.found_index = fidx_r;
  assign out_txn.live_count  = lcnt_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("live count above table depth");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_vld_vec) <= 1)
    else $error("more than one token in the cell chain");

  a_token_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tok_end.vld |-> state_r == ST_WALK)
    else $error("token left the chain outside a walk");

  a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> !in_rdy)
    else $error("input ready during a walk");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && !walk_done) |=> count_r == $past(count_r))
    else $error("live count changed in the middle of a walk");
`endif

endmodule
